@@ src/pszr_pkg.sv @@
// Shared types, constants and helper functions for the zero run-length print stream framer.
// No dependencies.
package pszr_pkg;

  localparam logic [7:0]  CharP        = 8'h50;
  localparam logic [7:0]  CharD        = 8'h44;
  localparam logic [7:0]  CharB        = 8'h42;
  localparam logic [7:0]  RunCap       = 8'd255;
  localparam logic [15:0] TimeoutReset = 16'd500;
  localparam logic [15:0] IdleMax      = 16'hFFFF;
  localparam logic        ModeData     = 1'b0;
  localparam logic        ModeTick     = 1'b1;

  // Output slot positions inside one command
  localparam int SlotPre0   = 0;
  localparam int SlotPre1   = 1;
  localparam int SlotHdrP   = 2;
  localparam int SlotHdrD   = 3;
  localparam int SlotHdrB   = 4;
  localparam int SlotHdrHex = 5;
  localparam int SlotRun0   = 6;
  localparam int SlotRunN   = 7;
  localparam int SlotData   = 8;
  localparam int SlotPost0  = 9;
  localparam int SlotPost1  = 10;
  localparam int NumSlots   = 11;
  localparam int SlotW      = 4;

  typedef logic [NumSlots-1:0] slot_mask_t;
  typedef logic [SlotW-1:0]    slot_idx_t;

  // One classified item: which byte groups to send and their payload
  typedef struct packed {
    logic       pre_term;
    logic       header;
    logic [3:0] chan;
    logic       flush;
    logic [7:0] run;
    logic       data_en;
    logic [7:0] data;
    logic       post_term;
    logic       printing;
  } cmd_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    if (v < 4'd10) begin
      return 8'h30 + {4'h0, v};
    end else begin
      return 8'h41 + {4'h0, v - 4'd10};
    end
  endfunction

  function automatic slot_mask_t cmd_mask(input cmd_t c);
    slot_mask_t m;
    m = '0;
    m[SlotPre0]   = c.pre_term;
    m[SlotPre1]   = c.pre_term;
    m[SlotHdrP]   = c.header;
    m[SlotHdrD]   = c.header;
    m[SlotHdrB]   = c.header;
    m[SlotHdrHex] = c.header;
    m[SlotRun0]   = c.flush;
    m[SlotRunN]   = c.flush;
    m[SlotData]   = c.data_en;
    m[SlotPost0]  = c.post_term;
    m[SlotPost1]  = c.post_term;
    return m;
  endfunction

endpackage

@@ src/pszr_front.sv @@
// Front end: takes data bytes and ticks, keeps session state, emits commands.
// Depends on pszr_pkg.
module pszr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr,
  input  logic [15:0]     cfg_data,
  input  logic            accept,
  input  logic            mode,
  input  logic [7:0]      byte_value,
  input  logic [3:0]      channel,
  output logic            cmd_push,
  output pszr_pkg::cmd_t  cmd
);
  import pszr_pkg::*;

  logic [15:0] idle_timeout_ticks;
  logic        session_open, session_open_next;
  logic [7:0]  zero_run, zero_run_next;
  logic [3:0]  last_channel, last_channel_next;
  logic [15:0] idle_count, idle_count_next;
  logic [15:0] idle_inc;
  logic        chan_change;

  assign chan_change = session_open && (channel != last_channel);
  assign idle_inc    = (idle_count == IdleMax) ? idle_count : idle_count + 16'd1;

  always_comb begin
    cmd                = '0;
    cmd.chan           = channel;
    cmd.data           = byte_value;
    session_open_next  = session_open;
    zero_run_next      = zero_run;
    last_channel_next  = last_channel;
    idle_count_next    = idle_count;
    if (mode == ModeData) begin
      cmd.pre_term      = chan_change;
      cmd.header        = !session_open || chan_change;
      session_open_next = 1'b1;
      last_channel_next = channel;
      idle_count_next   = '0;
      if (byte_value == 8'd0) begin
        if (!session_open) begin
          zero_run_next = 8'd1;
        end else if (zero_run < RunCap) begin
          zero_run_next = zero_run + 8'd1;
        end else begin
          cmd.flush     = 1'b1;
          cmd.run       = RunCap;
          zero_run_next = 8'd1;
        end
      end else begin
        cmd.flush     = session_open && (zero_run != 8'd0);
        cmd.run       = zero_run;
        cmd.data_en   = 1'b1;
        zero_run_next = '0;
      end
    end else if (session_open) begin
      idle_count_next = idle_inc;
      if (idle_inc >= idle_timeout_ticks) begin
        cmd.flush         = zero_run != 8'd0;
        cmd.run           = zero_run;
        cmd.post_term     = 1'b1;
        session_open_next = 1'b0;
        zero_run_next     = '0;
        idle_count_next   = '0;
      end
    end
    cmd.printing = session_open_next;
  end

  assign cmd_push = accept &&
                    (cmd.pre_term || cmd.header || cmd.flush || cmd.data_en || cmd.post_term);

  always_ff @(posedge clk) begin
    if (rst) begin
      idle_timeout_ticks <= TimeoutReset;
      session_open       <= 1'b0;
      zero_run           <= '0;
      last_channel       <= '0;
      idle_count         <= '0;
    end else begin
      if (cfg_wr) begin
        idle_timeout_ticks <= cfg_data;
      end
      if (accept) begin
        session_open <= session_open_next;
        zero_run     <= zero_run_next;
        last_channel <= last_channel_next;
        idle_count   <= idle_count_next;
      end
    end
  end

endmodule

@@ src/pszr_cmdq.sv @@
// Short command queue between front and back ends.
// Depends on pszr_pkg.
module pszr_cmdq #(
  parameter int Depth = 4
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  pszr_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd,
  output pszr_pkg::cmd_t rd_cmd,
  output logic           valid
);
  import pszr_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  cmd_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] count;
  logic            do_wr, do_rd;

  assign full   = count == CntW'(Depth);
  assign valid  = count != '0;
  assign do_wr  = wr && !full;
  assign do_rd  = rd && valid;
  assign rd_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_wr && !do_rd) begin
        count <= count + CntW'(1);
      end else if (do_rd && !do_wr) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

@@ src/pszr_back.sv @@
// Back end: expands one command into its output bytes, one per cycle while the output is popped.
// Depends on pszr_pkg.
module pszr_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  pszr_pkg::cmd_t q_cmd,
  output logic           q_rd,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     out_byte,
  output logic           last,
  output logic           printing
);
  import pszr_pkg::*;

  slot_mask_t pend, pend_next;
  cmd_t       cur;
  slot_idx_t  slot;
  logic       adv, is_last, out_valid;
  logic [7:0] byte_sel;

  always_comb begin
    slot = '0;
    for (int i = NumSlots - 1; i >= 0; i--) begin
      if (pend[i]) begin
        slot = SlotW'(i);
      end
    end
  end

  assign is_last = (pend & (pend - slot_mask_t'(1))) == '0;
  assign adv     = (pend != '0) && (!out_valid || pop);

  always_comb begin
    case (slot)
      SlotW'(SlotHdrP):   byte_sel = CharP;
      SlotW'(SlotHdrD):   byte_sel = CharD;
      SlotW'(SlotHdrB):   byte_sel = CharB;
      SlotW'(SlotHdrHex): byte_sel = hex_digit(cur.chan);
      SlotW'(SlotRunN):   byte_sel = cur.run;
      SlotW'(SlotData):   byte_sel = cur.data;
      default:            byte_sel = 8'd0;
    endcase
  end

  always_comb begin
    pend_next = pend;
    if (adv) begin
      pend_next = pend & ~(slot_mask_t'(1) << slot);
    end
  end

  assign q_rd  = q_valid && (pend_next == '0);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (q_rd) begin
      cur <= q_cmd;
    end
    if (adv) begin
      out_byte <= byte_sel;
      last     <= is_last;
      printing <= cur.printing;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= '0;
      out_valid <= 1'b0;
    end else begin
      pend <= q_rd ? cmd_mask(q_cmd) : pend_next;
      if (adv) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

@@ src/print_stream_zero_rle_framer.sv @@
// Top level of the zero run-length print stream framer.
// Depends on pszr_pkg, pszr_front, pszr_cmdq, pszr_back.
//
// Channel  Handshake       Payload
// input    push / full     mode, byte_value, channel
// result   empty / pop     out_byte, last, printing
// config   cfg_wr          cfg_data (idle_timeout_ticks)
//
// An item is classified in the cycle it is taken; its bytes leave one per
// cycle from the back end while the output register is popped, so a plain
// data byte makes one output byte and any item at most nine output bytes.
// The command queue (QUEUE_DEPTH entries) lets input continue while output
// stalls; full rises only when it fills. Synchronous reset, no clearing pass.
module print_stream_zero_rle_framer #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr,
  input  logic [15:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        mode,
  input  logic [7:0]  byte_value,
  input  logic [3:0]  channel,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last,
  output logic        printing
);
  import pszr_pkg::*;

  cmd_t f_cmd, q_cmd;
  logic f_push, q_valid, q_rd, accept;

  assign accept = push && !full;

  pszr_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr     (cfg_wr),
    .cfg_data   (cfg_data),
    .accept     (accept),
    .mode       (mode),
    .byte_value (byte_value),
    .channel    (channel),
    .cmd_push   (f_push),
    .cmd        (f_cmd)
  );

  pszr_cmdq #(
    .Depth (QUEUE_DEPTH)
  ) u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr     (f_push),
    .wr_cmd (f_cmd),
    .full   (full),
    .rd     (q_rd),
    .rd_cmd (q_cmd),
    .valid  (q_valid)
  );

  pszr_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_rd     (q_rd),
    .empty    (empty),
    .pop      (pop),
    .out_byte (out_byte),
    .last     (last),
    .printing (printing)
  );

endmodule
